[hdl/layout_record_stream_parser_unit_defines.svh]
// Assertion macros for the layout record stream parser checker.
// No dependencies; included by the checker file.
`ifndef LAYOUT_RECORD_STREAM_PARSER_UNIT_DEFINES_SVH
`define LAYOUT_RECORD_STREAM_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define LRSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrsp assertion failed");

// Next-cycle implication, disabled while reset is low.
`define LRSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrsp assertion failed");

`endif

[hdl/lrsp_pkg.sv]
// Shared types and record tag constants for the layout record stream parser.
// No dependencies.
package lrsp_pkg;

    localparam logic [15:0] TAG_STRNAME  = 16'h0606;
    localparam logic [15:0] TAG_ENDSTR   = 16'h0700;
    localparam logic [15:0] TAG_BOUNDARY = 16'h0800;
    localparam logic [15:0] TAG_SREF     = 16'h0A00;
    localparam logic [15:0] TAG_SNAME    = 16'h1206;
    localparam logic [15:0] TAG_LAYER    = 16'h0D02;
    localparam logic [15:0] TAG_PATH     = 16'h0900;
    localparam logic [15:0] TAG_PATHTYPE = 16'h2102;
    localparam logic [15:0] TAG_WIDTH    = 16'h0F03;
    localparam logic [15:0] TAG_XY       = 16'h1003;
    localparam logic [15:0] TAG_BOX      = 16'h2D00;

    typedef enum logic [2:0] {
        EV_POLY_VERTEX = 3'd0,
        EV_PATH_VERTEX = 3'd1,
        EV_REF_PLACE   = 3'd2,
        EV_STR_CHAR    = 3'd3,
        EV_REF_CHAR    = 3'd4,
        EV_STR_END     = 3'd5,
        EV_EMPTY_ELEM  = 3'd6
    } t_event_kind;

    typedef enum logic [1:0] {
        ELEM_NONE    = 2'd0,
        ELEM_POLYGON = 2'd1,
        ELEM_PATH    = 2'd2,
        ELEM_REF     = 2'd3
    } t_elem_kind;

    typedef struct packed {
        t_event_kind        event_kind;
        logic               inside_structure;
        logic [7:0]         layer_number;
        logic [7:0]         path_kind;
        logic signed [31:0] path_width;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [7:0]         name_char;
        logic               run_last;
    } t_event;

endpackage

[hdl/lrsp_if.sv]
// Valid/ready channels of the layout record stream parser: byte input, event output.
// Depends on lrsp_pkg.
interface lrsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       end_of_file;

    modport source (output valid, output stream_byte, output end_of_file, input ready);
    modport sink   (input valid, input stream_byte, input end_of_file, output ready);
endinterface

interface lrsp_event_if;
    import lrsp_pkg::*;

    logic               valid;
    logic               ready;
    t_event_kind        event_kind;
    logic               inside_structure;
    logic [7:0]         layer_number;
    logic [7:0]         path_kind;
    logic signed [31:0] path_width;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [7:0]         name_char;
    logic               run_last;

    modport source (
        output valid, output event_kind, output inside_structure, output layer_number,
        output path_kind, output path_width, output coord_x, output coord_y,
        output name_char, output run_last, input ready
    );
    modport sink (
        input valid, input event_kind, input inside_structure, input layer_number,
        input path_kind, input path_width, input coord_x, input coord_y,
        input name_char, input run_last, output ready
    );
endinterface

[hdl/layout_record_stream_parser_unit.sv]
// Layout record stream parser: one file byte per request, at most one event each.
// Events enter the output register, or the skid stage while that register is full.
// One byte per cycle while the skid stage is empty; the output register plus a
// one-entry skid stage keep i_stream.ready high while one event waits downstream.
// Reset (synchronous, i_rst_n low) clears all parse state and both output valid flags;
// a byte with end_of_file set returns the parser to its reset state after that byte.
module layout_record_stream_parser_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lrsp_byte_if.sink     i_stream,
    lrsp_event_if.source  o_event
);
    import lrsp_pkg::*;

    logic [31:0] r_window,   n_window;
    logic [2:0]  r_fill,     n_fill;
    logic [15:0] r_left,     n_left;
    logic [15:0] r_tag,      n_tag;
    logic        r_in_str,   n_in_str;
    t_elem_kind  r_elem,     n_elem;
    logic [7:0]  r_layer,    n_layer;
    logic [7:0]  r_ptype,    n_ptype;
    logic [31:0] r_width,    n_width;
    logic [63:0] r_pair,     n_pair;
    logic [2:0]  r_pcnt,     n_pcnt;
    logic [12:0] r_pairs,    n_pairs;

    t_event      r_out, r_skid, n_ev;
    logic        r_out_valid, r_skid_valid, n_has;

    logic        accept, take;
    logic [31:0] w;
    logic [15:0] len;
    logic [1:0]  slide;
    logic [2:0]  keep;
    logic        last;
    logic [2:0]  idx;
    logic        is_path;

    assign i_stream.ready = !r_skid_valid;
    assign accept = i_stream.valid && !r_skid_valid;
    assign take   = r_out_valid && o_event.ready;

    always_comb begin
        n_window = r_window;
        n_fill   = r_fill;
        n_left   = r_left;
        n_tag    = r_tag;
        n_in_str = r_in_str;
        n_elem   = r_elem;
        n_layer  = r_layer;
        n_ptype  = r_ptype;
        n_width  = r_width;
        n_pair   = r_pair;
        n_pcnt   = r_pcnt;
        n_pairs  = r_pairs;
        n_ev     = '0;
        n_has    = 1'b0;
        w        = {r_window[23:0], i_stream.stream_byte};
        len      = w[31:16];
        slide    = (len[1:0] == 2'd0) ? 2'd1 : len[1:0];
        keep     = 3'd4 - {1'b0, slide};
        last     = 1'b0;
        idx      = r_pcnt;
        is_path  = 1'b0;

        if (r_fill != 3'd4) begin
            n_window = w;
            n_fill   = 3'(r_fill + 3'd1);
            if (n_fill == 3'd4) begin
                if (len < 16'd4) begin
                    n_fill = keep;
                    case (keep)
                        3'd3:    n_window = {8'h00, w[23:0]};
                        3'd2:    n_window = {16'h0000, w[15:0]};
                        default: n_window = {24'h000000, w[7:0]};
                    endcase
                end else begin
                    n_tag    = w[15:0];
                    n_left   = len - 16'd4;
                    n_pcnt   = 3'd0;
                    n_window = '0;
                    // record start
                    if (n_elem != ELEM_NONE) begin
                        if (n_tag == TAG_WIDTH && n_elem == ELEM_PATH) begin
                            n_width = '0;
                        end
                        if (n_tag == TAG_XY) begin
                            if (n_left[15:3] == 13'd0) begin
                                is_path = (n_elem == ELEM_PATH);
                                n_has = 1'b1;
                                n_ev.event_kind       = EV_EMPTY_ELEM;
                                n_ev.inside_structure = n_in_str;
                                n_ev.layer_number     = (n_elem == ELEM_REF) ? 8'h00 : n_layer;
                                n_ev.path_kind        = is_path ? n_ptype : 8'h00;
                                n_ev.path_width       = is_path ? n_width : 32'h0;
                                n_ev.run_last         = 1'b1;
                                n_elem  = ELEM_NONE;
                                n_pairs = '0;
                            end else begin
                                n_pairs = (n_elem == ELEM_REF) ? 13'd1 : n_left[15:3];
                            end
                        end
                    end else begin
                        case (n_tag)
                            TAG_ENDSTR: begin
                                if (n_in_str) begin
                                    n_in_str = 1'b0;
                                    n_has = 1'b1;
                                    n_ev.event_kind       = EV_STR_END;
                                    n_ev.inside_structure = 1'b1;
                                    n_ev.run_last         = 1'b1;
                                end
                            end
                            TAG_BOUNDARY: n_elem = ELEM_POLYGON;
                            TAG_BOX:      n_elem = n_in_str ? ELEM_POLYGON : ELEM_NONE;
                            TAG_PATH:     n_elem = ELEM_PATH;
                            TAG_SREF:     n_elem = ELEM_REF;
                            default:      n_elem = ELEM_NONE;
                        endcase
                        if (n_elem != ELEM_NONE) begin
                            n_layer = '0;
                            n_ptype = '0;
                            n_width = '0;
                        end
                    end
                end
            end
        end else begin
            n_left = r_left - 16'd1;
            last   = (n_left == 16'd0);
            if (r_tag == TAG_XY) begin
                if (r_elem != ELEM_NONE && r_pairs != 13'd0) begin
                    n_pair = {r_pair[55:0], i_stream.stream_byte};
                    if (r_pcnt == 3'd7) begin
                        is_path = (r_elem == ELEM_PATH);
                        n_pcnt  = 3'd0;
                        n_pairs = r_pairs - 13'd1;
                        n_has   = 1'b1;
                        case (r_elem)
                            ELEM_POLYGON: n_ev.event_kind = EV_POLY_VERTEX;
                            ELEM_PATH:    n_ev.event_kind = EV_PATH_VERTEX;
                            default:      n_ev.event_kind = EV_REF_PLACE;
                        endcase
                        n_ev.inside_structure = r_in_str;
                        n_ev.layer_number     = (r_elem == ELEM_REF) ? 8'h00 : r_layer;
                        n_ev.path_kind        = is_path ? r_ptype : 8'h00;
                        n_ev.path_width       = is_path ? r_width : 32'h0;
                        n_ev.coord_x          = n_pair[63:32];
                        n_ev.coord_y          = n_pair[31:0];
                        n_ev.run_last         = (n_pairs == 13'd0);
                    end else begin
                        n_pcnt = 3'(r_pcnt + 3'd1);
                    end
                end
            end else begin
                if (r_elem != ELEM_NONE) begin
                    if (r_tag == TAG_LAYER && r_elem != ELEM_REF && idx == 3'd1) begin
                        n_layer = i_stream.stream_byte;
                    end else if (r_tag == TAG_PATHTYPE && r_elem == ELEM_PATH
                                 && idx == 3'd1) begin
                        n_ptype = i_stream.stream_byte;
                    end else if (r_tag == TAG_WIDTH && r_elem == ELEM_PATH
                                 && idx < 3'd4) begin
                        n_width = {r_width[23:0], i_stream.stream_byte};
                    end else if (r_tag == TAG_SNAME && r_elem == ELEM_REF) begin
                        n_has = 1'b1;
                        n_ev.event_kind       = EV_REF_CHAR;
                        n_ev.inside_structure = r_in_str;
                        n_ev.name_char        = i_stream.stream_byte;
                        n_ev.run_last         = last;
                    end
                end else if (r_tag == TAG_STRNAME && !r_in_str) begin
                    n_has = 1'b1;
                    n_ev.event_kind       = EV_STR_CHAR;
                    n_ev.inside_structure = 1'b1;
                    n_ev.name_char        = i_stream.stream_byte;
                    n_ev.run_last         = last;
                end
                if (r_pcnt != 3'd7) begin
                    n_pcnt = 3'(r_pcnt + 3'd1);
                end
            end
        end

        // record end
        if (n_fill == 3'd4 && n_left == 16'd0) begin
            if (n_tag == TAG_STRNAME && n_elem == ELEM_NONE && !n_in_str) begin
                n_in_str = 1'b1;
            end
            if (n_tag == TAG_XY && n_elem != ELEM_NONE) begin
                n_elem  = ELEM_NONE;
                n_pairs = '0;
            end
            n_pcnt = 3'd0;
            n_fill = 3'd0;
        end

        if (i_stream.end_of_file) begin
            n_window = '0;
            n_fill   = '0;
            n_left   = '0;
            n_tag    = '0;
            n_in_str = 1'b0;
            n_elem   = ELEM_NONE;
            n_layer  = '0;
            n_ptype  = '0;
            n_width  = '0;
            n_pair   = '0;
            n_pcnt   = '0;
            n_pairs  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= '0;
            r_fill       <= '0;
            r_left       <= '0;
            r_tag        <= '0;
            r_in_str     <= 1'b0;
            r_elem       <= ELEM_NONE;
            r_layer      <= '0;
            r_ptype      <= '0;
            r_width      <= '0;
            r_pair       <= '0;
            r_pcnt       <= '0;
            r_pairs      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_window <= n_window;
                r_fill   <= n_fill;
                r_left   <= n_left;
                r_tag    <= n_tag;
                r_in_str <= n_in_str;
                r_elem   <= n_elem;
                r_layer  <= n_layer;
                r_ptype  <= n_ptype;
                r_width  <= n_width;
                r_pair   <= n_pair;
                r_pcnt   <= n_pcnt;
                r_pairs  <= n_pairs;
            end
            if (r_skid_valid) begin
                if (take) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (accept && n_has) begin
                if (!r_out_valid || take) begin
                    r_out       <= n_ev;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= n_ev;
                    r_skid_valid <= 1'b1;
                end
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_event.valid            = r_out_valid;
    assign o_event.event_kind       = r_out.event_kind;
    assign o_event.inside_structure = r_out.inside_structure;
    assign o_event.layer_number     = r_out.layer_number;
    assign o_event.path_kind        = r_out.path_kind;
    assign o_event.path_width       = r_out.path_width;
    assign o_event.coord_x          = r_out.coord_x;
    assign o_event.coord_y          = r_out.coord_y;
    assign o_event.name_char        = r_out.name_char;
    assign o_event.run_last         = r_out.run_last;

endmodule

[hdl/lrsp_checker.sv]
// Port-level checks for layout_record_stream_parser_unit, bound into that module.
// Depends on lrsp_pkg and layout_record_stream_parser_unit_defines.svh.
`include "layout_record_stream_parser_unit_defines.svh"

module lrsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_kind,
    input logic        i_inside,
    input logic [7:0]  i_layer,
    input logic [7:0]  i_ptype,
    input logic [31:0] i_width,
    input logic        i_last
);
    import lrsp_pkg::*;

    `LRSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `LRSP_ASSERT_NOW(a_idle_ready, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    `LRSP_ASSERT_NOW(a_str_end, i_clk, i_rst_n, i_out_valid && i_kind == EV_STR_END,
        i_inside && i_last && i_layer == 8'h00)
    `LRSP_ASSERT_NOW(a_ref_plain, i_clk, i_rst_n, i_out_valid && i_kind == EV_REF_PLACE,
        i_layer == 8'h00 && i_ptype == 8'h00 && i_width == 32'h0)
    `LRSP_ASSERT_NEXT(a_reset_quiet, i_clk, i_rst_n, 1'b1, !($past(!i_rst_n) && i_out_valid))

endmodule

bind layout_record_stream_parser_unit lrsp_checker u_lrsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_stream.ready),
    .i_out_valid (o_event.valid),
    .i_out_ready (o_event.ready),
    .i_kind      (o_event.event_kind),
    .i_inside    (o_event.inside_structure),
    .i_layer     (o_event.layer_number),
    .i_ptype     (o_event.path_kind),
    .i_width     (o_event.path_width),
    .i_last      (o_event.run_last)
);

[tb/layout_record_stream_parser_unit_checker.sv]
// Checker for the layout record stream parser: follows the byte and event channels,
// predicts every event from the accepted bytes and compares it field by field.
// Depends on lrsp_pkg and the channel interfaces in lrsp_if.sv.
module layout_record_stream_parser_unit_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lrsp_byte_if  i_stream,
    lrsp_event_if i_event,
    output int    o_fail_count,
    output int    o_events_due,
    output int    o_events_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import lrsp_pkg::*;

    logic [31:0] hdr_win;
    logic [2:0]  hdr_fill;
    logic [15:0] bytes_left;
    logic [15:0] cur_tag;
    logic        in_str;
    t_elem_kind  elem;
    logic [7:0]  elem_layer;
    logic [7:0]  elem_ptype;
    logic [31:0] elem_width;
    logic [63:0] xy_buf;
    logic [2:0]  xy_idx;
    logic [15:0] pairs_due;

    t_event pending_events[$];
    t_event want;
    t_event got;
    int     mismatches = 0;
    int     seen = 0;

    function automatic void clear_parser();
        hdr_win    = '0;
        hdr_fill   = '0;
        bytes_left = '0;
        cur_tag    = '0;
        in_str     = 1'b0;
        elem       = ELEM_NONE;
        elem_layer = '0;
        elem_ptype = '0;
        elem_width = '0;
        xy_buf     = '0;
        xy_idx     = '0;
        pairs_due  = '0;
    endfunction

    function automatic t_event make_event(t_event_kind kind, logic in_s, logic [7:0] layer,
                                          logic [7:0] ptype, logic [31:0] width,
                                          logic [31:0] x, logic [31:0] y, logic [7:0] ch,
                                          logic last);
        t_event ev;
        ev.event_kind       = kind;
        ev.inside_structure = in_s;
        ev.layer_number     = layer;
        ev.path_kind        = ptype;
        ev.path_width       = width;
        ev.coord_x          = x;
        ev.coord_y          = y;
        ev.name_char        = ch;
        ev.run_last         = last;
        return ev;
    endfunction

    function automatic void start_element(t_elem_kind kind);
        elem       = kind;
        elem_layer = '0;
        elem_ptype = '0;
        elem_width = '0;
    endfunction

    function automatic bit open_record(output t_event ev);
        logic [15:0] pairs;
        bit          is_path;
        ev = '0;
        if (elem != ELEM_NONE) begin
            if (cur_tag == TAG_WIDTH && elem == ELEM_PATH)
                elem_width = '0;
            if (cur_tag == TAG_XY) begin
                pairs = {3'b000, bytes_left[15:3]};
                if (pairs == 16'd0) begin
                    is_path = (elem == ELEM_PATH);
                    ev = make_event(EV_EMPTY_ELEM, in_str,
                                    (elem == ELEM_REF) ? 8'h00 : elem_layer,
                                    is_path ? elem_ptype : 8'h00,
                                    is_path ? elem_width : 32'h0,
                                    32'h0, 32'h0, 8'h00, 1'b1);
                    elem      = ELEM_NONE;
                    pairs_due = '0;
                    return 1'b1;
                end
                pairs_due = (elem == ELEM_REF) ? 16'd1 : pairs;
            end
            return 1'b0;
        end
        case (cur_tag)
            TAG_ENDSTR: begin
                if (in_str) begin
                    in_str = 1'b0;
                    ev = make_event(EV_STR_END, 1'b1, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0,
                                    8'h00, 1'b1);
                    return 1'b1;
                end
            end
            TAG_BOUNDARY: start_element(ELEM_POLYGON);
            TAG_BOX: begin
                if (in_str)
                    start_element(ELEM_POLYGON);
            end
            TAG_PATH: start_element(ELEM_PATH);
            TAG_SREF: start_element(ELEM_REF);
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void close_record();
        if (cur_tag == TAG_STRNAME && elem == ELEM_NONE && !in_str)
            in_str = 1'b1;
        if (cur_tag == TAG_XY && elem != ELEM_NONE) begin
            elem      = ELEM_NONE;
            pairs_due = '0;
        end
        xy_idx   = '0;
        hdr_fill = '0;
    endfunction

    function automatic bit take_payload(logic [7:0] b, output t_event ev);
        logic        last;
        logic [2:0]  idx;
        bit          is_path;
        bit          hit;
        t_event_kind kind;
        ev   = '0;
        hit  = 1'b0;
        last = (bytes_left == 16'd0);
        idx  = xy_idx;
        if (cur_tag == TAG_XY) begin
            if (elem != ELEM_NONE && pairs_due != 16'd0) begin
                xy_buf = {xy_buf[55:0], b};
                if (xy_idx >= 3'd7) begin
                    is_path = (elem == ELEM_PATH);
                    kind = (elem == ELEM_POLYGON) ? EV_POLY_VERTEX :
                           (is_path ? EV_PATH_VERTEX : EV_REF_PLACE);
                    xy_idx = '0;
                    pairs_due--;
                    ev = make_event(kind, in_str, (elem == ELEM_REF) ? 8'h00 : elem_layer,
                                    is_path ? elem_ptype : 8'h00,
                                    is_path ? elem_width : 32'h0,
                                    xy_buf[63:32], xy_buf[31:0], 8'h00,
                                    pairs_due == 16'd0);
                    hit = 1'b1;
                end else begin
                    xy_idx++;
                end
            end
            return hit;
        end
        if (elem != ELEM_NONE) begin
            if (cur_tag == TAG_LAYER && elem != ELEM_REF && idx == 3'd1)
                elem_layer = b;
            else if (cur_tag == TAG_PATHTYPE && elem == ELEM_PATH && idx == 3'd1)
                elem_ptype = b;
            else if (cur_tag == TAG_WIDTH && elem == ELEM_PATH && idx < 3'd4)
                elem_width = {elem_width[23:0], b};
            else if (cur_tag == TAG_SNAME && elem == ELEM_REF) begin
                ev = make_event(EV_REF_CHAR, in_str, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0,
                                b, last);
                hit = 1'b1;
            end
        end else if (cur_tag == TAG_STRNAME && !in_str) begin
            ev = make_event(EV_STR_CHAR, 1'b1, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0, b, last);
            hit = 1'b1;
        end
        if (xy_idx < 3'd7)
            xy_idx++;
        return hit;
    endfunction

    // one accepted byte; returns 1 when it causes an event
    function automatic bit parse_byte(logic [7:0] b, logic eof, output t_event ev);
        logic [15:0] len;
        logic [2:0]  keep;
        bit          hit;
        ev  = '0;
        hit = 1'b0;
        if (hdr_fill < 3'd4) begin
            hdr_win = {hdr_win[23:0], b};
            hdr_fill++;
            if (hdr_fill == 3'd4) begin
                len = hdr_win[31:16];
                if (len < 16'd4) begin
                    // short length: slide the header window
                    keep = (len == 16'd0) ? 3'd3 : 3'd4 - len[2:0];
                    hdr_fill = keep;
                    case (keep)
                        3'd3:    hdr_win = hdr_win & 32'h00FF_FFFF;
                        3'd2:    hdr_win = hdr_win & 32'h0000_FFFF;
                        default: hdr_win = hdr_win & 32'h0000_00FF;
                    endcase
                end else begin
                    cur_tag    = hdr_win[15:0];
                    bytes_left = len - 16'd4;
                    xy_idx     = '0;
                    hdr_win    = '0;
                    hit = open_record(ev);
                    if (bytes_left == 16'd0)
                        close_record();
                end
            end
        end else begin
            bytes_left--;
            hit = take_payload(b, ev);
            if (bytes_left == 16'd0)
                close_record();
        end
        if (eof)
            clear_parser();
        return hit;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
        end
    endtask

    initial clear_parser();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            pending_events.delete();
        end else begin
            if (i_stream.valid && i_stream.ready) begin
                if (parse_byte(i_stream.stream_byte, i_stream.end_of_file, want))
                    pending_events.insert(pending_events.size(), want);
            end
            if (i_event.valid && i_event.ready) begin
                got.event_kind       = i_event.event_kind;
                got.inside_structure = i_event.inside_structure;
                got.layer_number     = i_event.layer_number;
                got.path_kind        = i_event.path_kind;
                got.path_width       = i_event.path_width;
                got.coord_x          = i_event.coord_x;
                got.coord_y          = i_event.coord_y;
                got.name_char        = i_event.name_char;
                got.run_last         = i_event.run_last;
                seen++;
                if (pending_events.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected event, expected none, actual kind %0d",
                             $time, got.event_kind);
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
                    check_field("inside_structure", 32'(want.inside_structure),
                                32'(got.inside_structure));
                    check_field("layer_number", 32'(want.layer_number),
                                32'(got.layer_number));
                    check_field("path_kind", 32'(want.path_kind), 32'(got.path_kind));
                    check_field("path_width", want.path_width, got.path_width);
                    check_field("coord_x", want.coord_x, got.coord_x);
                    check_field("coord_y", want.coord_y, got.coord_y);
                    check_field("name_char", 32'(want.name_char), 32'(got.name_char));
                    check_field("run_last", 32'(want.run_last), 32'(got.run_last));
                end
            end
        end
        o_fail_count  <= mismatches;
        o_events_due  <= pending_events.size();
        o_events_seen <= seen;
    end

endmodule

[tb/layout_record_stream_parser_unit_tb.sv]
// Top of the layout record stream parser testbench: clock, reset, layout file stimulus
// with random idling on both channels, and the verdict. Depends on lrsp_pkg,
// lrsp_if.sv, the parser RTL and layout_record_stream_parser_unit_checker.
module layout_record_stream_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrsp_pkg::*;

    localparam logic [15:0] TAG_LIBHDR = 16'h0002;
    localparam logic [15:0] TAG_ENDEL  = 16'h1100;
    localparam int RANDOM_BYTES = 420;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int events_due;
    int events_seen;
    int bytes_sent = 0;
    int files_sent = 0;
    int random_start;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    logic [7:0] file_bytes[$];
    logic [7:0] body[$];

    always #2 clk = ~clk;

    lrsp_byte_if  stream_if ();
    lrsp_event_if event_if ();

    layout_record_stream_parser_unit u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_stream (stream_if),
        .o_event  (event_if)
    );

    layout_record_stream_parser_unit_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_stream      (stream_if),
        .i_event       (event_if),
        .o_fail_count  (fail_count),
        .o_events_due  (events_due),
        .o_events_seen (events_seen)
    );

    function automatic void body_byte(logic [7:0] b);
        body.insert(body.size(), b);
    endfunction

    function automatic void file_byte(logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endfunction

    function automatic void body_rand(int n);
        repeat (n) body_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void body_word(logic [31:0] w);
        body_byte(w[31:24]);
        body_byte(w[23:16]);
        body_byte(w[15:8]);
        body_byte(w[7:0]);
    endfunction

    function automatic void add_record(logic [15:0] tag);
        logic [15:0] len;
        len = 16'(body.size() + 4);
        file_byte(len[15:8]);
        file_byte(len[7:0]);
        file_byte(tag[15:8]);
        file_byte(tag[7:0]);
        foreach (body[i]) file_byte(body[i]);
        body.delete();
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic int attr_len(int norm);
        return ($urandom_range(0, 3) != 0) ? norm : $urandom_range(0, norm + 2);
    endfunction

    function automatic void add_stray();
        body_rand($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0:       add_record(TAG_ENDEL);
            1:       add_record(TAG_ENDSTR);
            2:       add_record(TAG_STRNAME);
            3:       add_record(TAG_SNAME);
            4:       add_record(TAG_XY);
            default: add_record(TAG_BOUNDARY);
        endcase
    endfunction

    function automatic void add_element();
        int kind;
        int pairs;
        kind = $urandom_range(0, 3);
        case (kind)
            0:       add_record(TAG_BOUNDARY);
            1:       add_record(TAG_BOX);
            2:       add_record(TAG_PATH);
            default: add_record(TAG_SREF);
        endcase
        if (kind == 3) begin
            body_rand($urandom_range(1, 8));
            add_record(TAG_SNAME);
        end else begin
            body_rand(attr_len(2));
            add_record(TAG_LAYER);
            if (kind == 2) begin
                body_rand(attr_len(2));
                add_record(TAG_PATHTYPE);
                body_rand(attr_len(4));
                add_record(TAG_WIDTH);
            end
        end
        if ($urandom_range(0, 7) == 0)
            add_stray();
        pairs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, (kind == 3) ? 2 : 5);
        repeat (pairs) begin
            body_word(pick_coord());
            body_word(pick_coord());
        end
        if ($urandom_range(0, 5) == 0)
            body_rand($urandom_range(1, 7));
        add_record(TAG_XY);
        add_record(TAG_ENDEL);
    endfunction

    function automatic logic [7:0] noise_byte();
        return 8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
    endfunction

    function automatic void build_random_file();
        int cut;
        file_bytes.delete();
        body_rand(2);
        add_record(TAG_LIBHDR);
        if ($urandom_range(0, 4) == 0)
            add_element();
        repeat ($urandom_range(1, 3)) begin
            body_rand(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
            add_record(TAG_STRNAME);
            repeat ($urandom_range(0, 4)) add_element();
            if ($urandom_range(0, 9) == 0)
                add_stray();
            if ($urandom_range(0, 9) != 0)
                add_record(TAG_ENDSTR);
        end
        case ($urandom_range(0, 7))
            0: begin
                cut = $urandom_range(1, file_bytes.size() - 1);
                while (file_bytes.size() > cut) file_bytes.delete(file_bytes.size() - 1);
            end
            1: begin
                repeat ($urandom_range(1, 4))
                    file_bytes.insert($urandom_range(0, file_bytes.size() - 1), noise_byte());
            end
            2: begin
                file_bytes.delete();
                repeat ($urandom_range(8, 24)) file_byte(noise_byte());
            end
            default: ;
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            stream_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_if.valid       <= 1'b1;
        stream_if.stream_byte <= b;
        stream_if.end_of_file <= eof;
        @(posedge clk);
        while (!stream_if.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        tx_steady = ($urandom_range(0, 3) == 0);
        foreach (file_bytes[i]) put_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    // event receiver; one long hold-off lets the block fill and stall its input
    initial begin : event_sink
        int gap;
        int taken;
        taken = 0;
        event_if.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken % 32 == 0)
                rx_steady = ($urandom_range(0, 2) == 0);
            gap = rx_steady ? 0 : $urandom_range(0, 4);
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0) begin
                event_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            event_if.ready <= 1'b1;
            @(posedge clk);
            while (!event_if.valid) @(posedge clk);
            taken++;
        end
    end

    initial begin : byte_source
        stream_if.valid       = 1'b0;
        stream_if.stream_byte = 8'h00;
        stream_if.end_of_file = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray records at top level, empty name, named structure with all elements
        file_bytes.delete();
        add_record(TAG_ENDSTR);
        add_record(TAG_BOX);
        body_word(32'h0000_0010);
        body_word(32'h0000_0020);
        add_record(TAG_XY);
        body_byte(8'h78);
        add_record(TAG_SNAME);
        add_record(TAG_STRNAME);
        add_record(TAG_ENDSTR);
        body_byte(8'h00);
        body_byte(8'hFF);
        body_byte(8'h41);
        add_record(TAG_STRNAME);
        body_byte(8'h5A);
        add_record(TAG_STRNAME);
        add_record(TAG_BOUNDARY);
        body_byte(8'h00);
        body_byte(8'hFF);
        body_byte(8'h12);
        add_record(TAG_LAYER);
        add_record(TAG_PATH);
        add_record(TAG_ENDSTR);
        body_word(32'h7FFF_FFFF);
        body_word(32'h8000_0000);
        body_word(32'h0000_0000);
        body_word(32'hFFFF_FFFF);
        body_rand(3);
        add_record(TAG_XY);
        add_record(TAG_ENDEL);
        add_record(TAG_BOX);
        body_byte(8'h05);
        add_record(TAG_LAYER);
        body_word(pick_coord());
        body_word(pick_coord());
        add_record(TAG_XY);
        add_record(TAG_PATH);
        body_byte(8'h00);
        body_byte(8'h02);
        add_record(TAG_PATHTYPE);
        body_byte(8'h12);
        body_byte(8'h34);
        add_record(TAG_WIDTH);
        body_word(32'h8000_0001);
        add_record(TAG_WIDTH);
        repeat (4) body_word(pick_coord());
        add_record(TAG_XY);
        add_record(TAG_PATH);
        body_byte(8'hAB);
        body_byte(8'hCD);
        add_record(TAG_WIDTH);
        body_rand(5);
        add_record(TAG_XY);
        add_record(TAG_SREF);
        body_byte(8'h41);
        body_byte(8'h42);
        add_record(TAG_SNAME);
        repeat (6) body_word(pick_coord());
        add_record(TAG_XY);
        add_record(TAG_SREF);
        add_record(TAG_XY);
        add_record(TAG_BOUNDARY);
        body_rand(4);
        add_record(TAG_XY);
        add_record(TAG_ENDSTR);
        add_record(TAG_BOUNDARY);
        body_byte(8'h00);
        body_byte(8'h07);
        add_record(TAG_LAYER);
        body_word(pick_coord());
        body_word(pick_coord());
        add_record(TAG_XY);
        send_file();

        // header lengths 0 to 3
        file_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h03,
                       8'h00, 8'h08, 8'h06, 8'h06, 8'h41, 8'h42, 8'h43, 8'h44};
        send_file();

        // end of file in the middle of a name
        file_bytes.delete();
        body_rand(6);
        add_record(TAG_STRNAME);
        while (file_bytes.size() > 7) file_bytes.delete(file_bytes.size() - 1);
        send_file();

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            build_random_file();
            send_file();
        end
        stream_if.valid <= 1'b0;

        @(posedge clk);
        while (events_due != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        $display("covered %0d bytes in %0d layout files, %0d events checked",
                 bytes_sent, files_sent, events_seen);
        if (fail_count == 0 && events_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : run_limit
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/lrsp_pkg.sv
hdl/lrsp_if.sv
hdl/layout_record_stream_parser_unit.sv
hdl/lrsp_checker.sv
tb/layout_record_stream_parser_unit_checker.sv
tb/layout_record_stream_parser_unit_tb.sv
